@@ rtl/tcw_pkg.sv @@
package tcw_pkg;

	// operation codes
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_COLOR = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// control characters
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam int unsigned TAB_STEP = 8;

	localparam logic [7:0] BLANK_ATTR  = 8'h02;
	localparam logic [7:0] COLOR_RST   = 8'h07;
	localparam logic [7:0] COLOR_LAST  = 8'h0F;
	localparam logic [7:0] COLOR_FIRST = 8'h01;

	// wide enough for any row*COLUMNS+col in the parameter range
	localparam int unsigned POS_W = 12;
	localparam int unsigned OUT_POS_W = 11;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_SCROLL,
		ST_BLANK,
		ST_RESP
	} tcw_state_t;

	typedef struct packed {
		logic we_chr;
		logic we_atr;
	} tcw_wr_ctl_t;

endpackage

@@ rtl/tcw_cell_mem.sv @@
module tcw_cell_mem import tcw_pkg::*; #(
	parameter int unsigned DEPTH  = 2000,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  tcw_wr_ctl_t       wr,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_chr,
	input  logic [7:0]        wr_atr,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_chr_q,
	output logic [7:0]        rd_atr_q
);

	// character and attribute planes, separate so a backspace keeps the attribute
	logic [7:0] chr_mem [DEPTH];
	logic [7:0] atr_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we_chr)
			chr_mem[wr_addr] <= wr_chr;
		if (wr.we_atr)
			atr_mem[wr_addr] <= wr_atr;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_chr_q <= chr_mem[rd_addr];
			rd_atr_q <= atr_mem[rd_addr];
		end
	end

endmodule

@@ rtl/text_console_writer.sv @@
// Text console writer: put char / clear / set color / read cell over a cell store.
// Results are registered: an accepted put, set color or read word moves to ST_RESP,
// which loads the output register. A clear sweeps every cell of the store; a put that
// scrolls shares the one memory write port: copy of ROWS-2 rows, then blanking of the
// last two rows. One word in flight: no new word is taken until the last result is
// loaded. After arst_n rises, a pass over every cell blanks the store with in_ready low.
module text_console_writer import tcw_pkg::*; #(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  char_code,
	input  logic [3:0]  fg_nibble,
	input  logic [3:0]  bg_nibble,
	input  logic [10:0] cell_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] cursor_position,
	output logic [7:0]  read_char,
	output logic [7:0]  read_attribute,
	output logic [7:0]  color_now
);

	localparam int unsigned CELLS  = ROWS * COLUMNS;
	localparam int unsigned ADDR_W = $clog2(CELLS);
	localparam int unsigned COL_W  = $clog2(COLUMNS);
	localparam int unsigned ROW_W  = $clog2(ROWS);
	// column plus one tab step still fits here
	localparam int unsigned CX_W   = COL_W + 1;
	// cells moved up by a scroll: rows 1..ROWS-2 into rows 0..ROWS-3
	localparam int unsigned COPY_N = (ROWS - 2) * COLUMNS;

	tcw_state_t state_q, state_d;

	logic [ADDR_W-1:0] ptr_q, ptr_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [7:0]        color_q, color_d;
	logic [1:0]        op_q, op_d;
	logic              rd_ok_q, rd_ok_d;

	// scroll copy: the read is issued from ST_SCROLL and written back in the next cycle
	logic              cp_vld_s1;
	logic [ADDR_W-1:0] cp_addr_s1;

	logic              out_valid_q;
	logic              load_out;
	logic [10:0]       pos_out_q;
	logic [7:0]        rchr_out_q, ratr_out_q, color_out_q;

	// memory port signals
	tcw_wr_ctl_t       wr;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [7:0]        wr_chr, wr_atr;
	logic              rd_en;
	logic [7:0]        rd_chr_q, rd_atr_q;

	// put-char datapath
	logic [POS_W-1:0]  pos_cur;
	logic [CX_W-1:0]   col_x, col_8;
	logic [ROW_W-1:0]  row_x;
	logic [POS_W-1:0]  pos_now;

	assign pos_cur = POS_W'(row_q) * POS_W'(COLUMNS) + POS_W'(col_q);
	assign col_8   = CX_W'(col_q) + CX_W'(TAB_STEP);
	assign pos_now = POS_W'(row_q) * POS_W'(COLUMNS) + POS_W'(col_q);

	tcw_cell_mem #(
		.DEPTH  (CELLS),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk      (clk),
		.wr       (wr),
		.wr_addr  (wr_addr),
		.wr_chr   (wr_chr),
		.wr_atr   (wr_atr),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_chr_q (rd_chr_q),
		.rd_atr_q (rd_atr_q)
	);

	always_comb begin
		state_d  = state_q;
		ptr_d    = ptr_q;
		col_d    = col_q;
		row_d    = row_q;
		color_d  = color_q;
		op_d     = op_q;
		rd_ok_d  = rd_ok_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		wr       = '0;
		wr_addr  = ptr_q;
		wr_chr   = 8'h00;
		wr_atr   = BLANK_ATTR;
		rd_en    = 1'b0;
		rd_addr  = ADDR_W'(ptr_q + ADDR_W'(COLUMNS));
		col_x    = CX_W'(col_q);
		row_x    = row_q;

		// pending scroll copy owns the write port
		if (cp_vld_s1) begin
			wr      = '{we_chr: 1'b1, we_atr: 1'b1};
			wr_addr = cp_addr_s1;
			wr_chr  = rd_chr_q;
			wr_atr  = rd_atr_q;
		end

		case (state_q)
			ST_INIT, ST_CLEAR: begin
				wr      = '{we_chr: 1'b1, we_atr: 1'b1};
				wr_addr = ptr_q;
				if (ptr_q == ADDR_W'(CELLS - 1)) begin
					ptr_d   = '0;
					state_d = (state_q == ST_INIT) ? ST_IDLE : ST_RESP;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_IDLE: begin
				// in_ready is high here, so valid alone takes the word
				in_ready = 1'b1;
				if (in_valid) begin
					op_d    = op;
					rd_ok_d = 1'b0;
					state_d = ST_RESP;
					case (op)
						OP_PUT: begin
							case (char_code)
								CH_BS: begin
									if (col_q != '0) begin
										col_x   = CX_W'(col_q) - 1'b1;
										wr.we_chr = 1'b1;
										wr_addr = ADDR_W'(pos_cur - 1'b1);
										wr_chr  = 8'h00;
									end
								end
								CH_TAB: col_x = col_8 & ~CX_W'(TAB_STEP - 1);
								CH_CR:  col_x = '0;
								CH_LF: begin
									col_x = '0;
									row_x = row_q + 1'b1;
								end
								default: begin
									color_d = (color_q <= COLOR_LAST) ? color_q + 8'd1
										: COLOR_FIRST;
									wr      = '{we_chr: 1'b1, we_atr: 1'b1};
									wr_addr = ADDR_W'(pos_cur);
									wr_chr  = char_code;
									wr_atr  = color_d;
									col_x   = CX_W'(col_q) + 1'b1;
								end
							endcase
							if (col_x >= CX_W'(COLUMNS)) begin
								col_x = '0;
								row_x = row_x + 1'b1;
							end
							if (row_x >= ROW_W'(ROWS - 1)) begin
								row_x   = row_x - 1'b1;
								ptr_d   = '0;
								state_d = ST_SCROLL;
							end
							col_d = COL_W'(col_x);
							row_d = row_x;
						end
						OP_CLEAR: begin
							col_d   = '0;
							row_d   = '0;
							ptr_d   = '0;
							state_d = ST_CLEAR;
						end
						OP_COLOR: color_d = {bg_nibble, fg_nibble};
						OP_READ: begin
							rd_en   = 1'b1;
							rd_addr = ADDR_W'(POS_W'(cell_index));
							rd_ok_d = POS_W'(cell_index) < POS_W'(CELLS);
						end
						default: ;
					endcase
				end
			end
			ST_SCROLL: begin
				rd_en = 1'b1;
				if (ptr_q == ADDR_W'(COPY_N - 1)) begin
					ptr_d   = ADDR_W'(COPY_N);
					state_d = ST_BLANK;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_BLANK: begin
				if (!cp_vld_s1) begin
					wr      = '{we_chr: 1'b1, we_atr: 1'b1};
					wr_addr = ptr_q;
					if (ptr_q == ADDR_W'(CELLS - 1)) begin
						ptr_d   = '0;
						state_d = ST_RESP;
					end else begin
						ptr_d = ptr_q + 1'b1;
					end
				end
			end
			ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			ptr_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			color_q     <= COLOR_RST;
			cp_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ptr_q     <= ptr_d;
			col_q     <= col_d;
			row_q     <= row_d;
			color_q   <= color_d;
			cp_vld_s1 <= (state_q == ST_SCROLL);
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		op_q       <= op_d;
		rd_ok_q    <= rd_ok_d;
		cp_addr_s1 <= ptr_q;
		if (load_out) begin
			pos_out_q   <= pos_now[OUT_POS_W-1:0];
			color_out_q <= color_q;
			if (op_q == OP_READ && rd_ok_q) begin
				rchr_out_q <= rd_chr_q;
				ratr_out_q <= rd_atr_q;
			end else begin
				rchr_out_q <= 8'h00;
				ratr_out_q <= 8'h00;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign cursor_position = pos_out_q;
	assign read_char       = rchr_out_q;
	assign read_attribute  = ratr_out_q;
	assign color_now       = color_out_q;

endmodule

@@ rtl/tcw_checker.sv @@
module tcw_checker #(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [10:0] cursor_position,
	input logic [7:0]  read_char,
	input logic [7:0]  read_attribute,
	input logic [7:0]  color_now
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cursor_position)
			&& $stable(read_char) && $stable(read_attribute) && $stable(color_now))
		else $error("result word changed while stalled");

	// one word in flight: in_ready is low in the cycle after an input word is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted back to back");

	// scrolling keeps the cursor above the last row
	a_cursor_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> int'(cursor_position) < (ROWS - 1) * COLUMNS
			|| (ROWS - 1) * COLUMNS > 2047)
		else $error("cursor on or past last row");

	// no result word on the first edge after reset
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !out_valid)
		else $error("result word right after reset");

endmodule

bind text_console_writer tcw_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_tcw_checker (.*);

@@ sim/text_console_writer_tb.sv @@
module text_console_writer_tb import tcw_pkg::*;;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int N_WORDS = 1550;

	// one input word and one result word, as they stand on the ports
	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  ch;
		logic [3:0]  fg;
		logic [3:0]  bg;
		logic [10:0] idx;
	} console_word_t;

	typedef struct packed {
		logic [10:0] pos;
		logic [7:0]  chr;
		logic [7:0]  atr;
		logic [7:0]  color;
	} cell_result_t;

	// directed row: word, repeat count, and a hand-typed result where obvious
	typedef struct packed {
		console_word_t w;
		int            reps;
		bit            typed;
		cell_result_t  res;
	} step_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [7:0]  char_code;
	logic [3:0]  fg_nibble;
	logic [3:0]  bg_nibble;
	logic [10:0] cell_index;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [10:0] cursor_position;
	logic [7:0]  read_char;
	logic [7:0]  read_attribute;
	logic [7:0]  color_now;

	// shadow of the console: cell store, cursor and color register
	logic [7:0] shadow_chr [CELLS];
	logic [7:0] shadow_atr [CELLS];
	int         cur_col;
	int         cur_row;
	logic [7:0] shadow_color;

	cell_result_t expected_q [$];
	int  words_sent;
	int  results_seen;
	int  fail_count;
	int  n_scroll;
	int  n_wrap;
	int  n_clear;
	int  n_oob;
	bit  steady;	// no idling on either side while set

	step_row_t dir_tab [23];

	text_console_writer #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.char_code      (char_code),
		.fg_nibble      (fg_nibble),
		.bg_nibble      (bg_nibble),
		.cell_index     (cell_index),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cursor_position(cursor_position),
		.read_char      (read_char),
		.read_attribute (read_attribute),
		.color_now      (color_now)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop well past the slowest legal run (every sweep, every stall)
	initial begin
		#200_000_000;
		$display("FAIL text_console_writer");
		$finish;
	end

	function automatic void blank_screen();
		for (int i = 0; i < CELLS; i++) begin
			shadow_chr[i] = 8'h00;
			shadow_atr[i] = BLANK_ATTR;
		end
	endfunction

	// advance the shadow console by one word and return the result it gives
	function automatic cell_result_t console_step(console_word_t w);
		cell_result_t r;
		int p;
		r = '0;
		case (w.op)
			OP_PUT: begin
				if (w.ch == CH_BS) begin
					// backspace at column 0 does nothing; attribute is kept
					if (cur_col > 0) begin
						cur_col--;
						shadow_chr[cur_row * COLUMNS + cur_col] = 8'h00;
					end
				end else if (w.ch == CH_TAB) begin
					cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
				end else if (w.ch == CH_CR) begin
					cur_col = 0;
				end else if (w.ch == CH_LF) begin
					cur_col = 0;
					cur_row++;
				end else begin
					// color steps before the write: 15 -> 16, anything above 15 -> 1
					shadow_color = (shadow_color <= COLOR_LAST) ? 8'(shadow_color + 1) :
						COLOR_FIRST;
					p = cur_row * COLUMNS + cur_col;
					shadow_chr[p] = w.ch;
					shadow_atr[p] = shadow_color;
					cur_col++;
				end
				if (cur_col >= COLUMNS) begin
					cur_col = 0;
					cur_row++;
					n_wrap++;
				end
				// scroll up one row, last two rows come back blank
				if (cur_row >= ROWS - 1) begin
					for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
						shadow_chr[i] = shadow_chr[i + COLUMNS];
						shadow_atr[i] = shadow_atr[i + COLUMNS];
					end
					for (int i = (ROWS - 2) * COLUMNS; i < CELLS; i++) begin
						shadow_chr[i] = 8'h00;
						shadow_atr[i] = BLANK_ATTR;
					end
					cur_row--;
					n_scroll++;
				end
			end
			OP_CLEAR: begin
				blank_screen();
				cur_col = 0;
				cur_row = 0;
				n_clear++;
			end
			OP_COLOR: shadow_color = {w.bg, w.fg};
			default: begin
				if (w.idx < CELLS) begin
					r.chr = shadow_chr[w.idx];
					r.atr = shadow_atr[w.idx];
				end else begin
					n_oob++;	// past the store reads as zero
				end
			end
		endcase
		r.pos   = 11'(cur_row * COLUMNS + cur_col);
		r.color = shadow_color;
		return r;
	endfunction

	function automatic console_word_t random_word();
		console_word_t w;
		w.op  = 2'($urandom_range(3));
		w.ch  = 8'($urandom_range(255));
		w.fg  = 4'($urandom_range(15));
		w.bg  = 4'($urandom_range(15));
		w.idx = 11'($urandom_range(2047));
		return w;
	endfunction

	// present one word, hold it until taken, then log what should come back
	task automatic send_word(console_word_t w, bit typed, cell_result_t typed_res);
		cell_result_t res;
		while (!steady && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= w.op;
		char_code  <= w.ch;
		fg_nibble  <= w.fg;
		bg_nibble  <= w.bg;
		cell_index <= w.idx;
		do @(posedge clk); while (!in_ready);
		res = console_step(w);
		expected_q.push_back(typed ? typed_res : res);
		words_sent++;
	endtask

	// receiver backpressure
	always @(posedge clk)
		out_ready <= steady || ($urandom_range(99) >= 34);

	// result checker
	always @(posedge clk) begin : result_check
		cell_result_t got;
		cell_result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {cursor_position, read_char, read_attribute, color_now};
			results_seen++;
			if (expected_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: result word with nothing pending: pos %0d char %h attr %h color %h",
						$time, got.pos, got.chr, got.atr, got.color);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: mismatch pos %0d/%0d char %h/%h attr %h/%h color %h/%h (exp/got)",
							$time, want.pos, got.pos, want.chr, got.chr, want.atr, got.atr,
							want.color, got.color);
				end
			end
		end
	end

	initial begin : main
		console_word_t w;
		logic [7:0] c;
		int kind;
		int n;
		int at;
		bit drained;

		in_valid   = 1'b0;
		op         = OP_PUT;
		char_code  = 8'h00;
		fg_nibble  = 4'h0;
		bg_nibble  = 4'h0;
		cell_index = 11'd0;
		arst_n     = 1'b0;
		steady     = 1'b0;
		drained    = 1'b0;
		words_sent = 0;
		results_seen = 0;
		fail_count = 0;
		n_scroll = 0;
		n_wrap = 0;
		n_clear = 0;
		n_oob = 0;
		blank_screen();
		cur_col = 0;
		cur_row = 0;
		shadow_color = COLOR_RST;

		// directed rows; typed results follow from reset state by hand
		dir_tab = '{
			// fresh store after reset, first and last cell, then past the end
			'{'{OP_READ, 8'h00, 4'h0, 4'h0, 11'd0}, 1, 1'b1,
				'{11'd0, 8'h00, BLANK_ATTR, COLOR_RST}},
			'{'{OP_READ, 8'h00, 4'h0, 4'h0, 11'd1999}, 1, 1'b1,
				'{11'd0, 8'h00, BLANK_ATTR, COLOR_RST}},
			'{'{OP_READ, 8'h00, 4'h0, 4'h0, 11'd2000}, 1, 1'b1,
				'{11'd0, 8'h00, 8'h00, COLOR_RST}},
			'{'{OP_READ, 8'hFF, 4'hF, 4'hF, 11'd2047}, 1, 1'b1,
				'{11'd0, 8'h00, 8'h00, COLOR_RST}},
			// color above 15 wraps to 1 on the next print
			'{'{OP_COLOR, 8'h00, 4'hF, 4'hF, 11'd0}, 1, 1'b1, '{11'd0, 8'h00, 8'h00, 8'hFF}},
			'{'{OP_PUT, 8'h41, 4'h0, 4'h0, 11'd0}, 1, 1'b1, '{11'd1, 8'h00, 8'h00, 8'h01}},
			// color 15 steps to 16, then 16 wraps to 1
			'{'{OP_COLOR, 8'h00, 4'hF, 4'h0, 11'd0}, 1, 1'b1, '{11'd1, 8'h00, 8'h00, 8'h0F}},
			'{'{OP_PUT, 8'hFF, 4'h0, 4'h0, 11'd0}, 1, 1'b1, '{11'd2, 8'h00, 8'h00, 8'h10}},
			'{'{OP_PUT, 8'h00, 4'h0, 4'h0, 11'd0}, 1, 1'b1, '{11'd3, 8'h00, 8'h00, 8'h01}},
			'{'{OP_READ, 8'h00, 4'h0, 4'h0, 11'd1}, 1, 1'b1, '{11'd3, 8'hFF, 8'h10, 8'h01}},
			// backspace blanks the char, keeps the attribute
			'{'{OP_PUT, CH_BS, 4'h0, 4'h0, 11'd0}, 1, 1'b1, '{11'd2, 8'h00, 8'h00, 8'h01}},
			'{'{OP_READ, 8'h00, 4'h0, 4'h0, 11'd2}, 1, 1'b1, '{11'd2, 8'h00, 8'h01, 8'h01}},
			'{'{OP_PUT, CH_TAB, 4'h0, 4'h0, 11'd0}, 1, 1'b1, '{11'd8, 8'h00, 8'h00, 8'h01}},
			'{'{OP_PUT, CH_CR, 4'h0, 4'h0, 11'd0}, 1, 1'b1, '{11'd0, 8'h00, 8'h00, 8'h01}},
			'{'{OP_PUT, CH_LF, 4'h0, 4'h0, 11'd0}, 1, 1'b1, '{11'd80, 8'h00, 8'h00, 8'h01}},
			// backspace at column 0 is a no-op
			'{'{OP_PUT, CH_BS, 4'h0, 4'h0, 11'd0}, 1, 1'b1, '{11'd80, 8'h00, 8'h00, 8'h01}},
			'{'{OP_COLOR, 8'h00, 4'h0, 4'h0, 11'd0}, 1, 1'b1, '{11'd80, 8'h00, 8'h00, 8'h00}},
			'{'{OP_PUT, 8'h7E, 4'h0, 4'h0, 11'd0}, 1, 1'b1, '{11'd81, 8'h00, 8'h00, 8'h01}},
			// tabs run off the end of the row and wrap
			'{'{OP_PUT, CH_TAB, 4'h0, 4'h0, 11'd0}, 10, 1'b0, '0},
			'{'{OP_READ, 8'h00, 4'h0, 4'h0, 11'd80}, 1, 1'b1, '{11'd160, 8'h7E, 8'h01, 8'h01}},
			'{'{OP_COLOR, 8'h00, 4'h5, 4'hA, 11'd0}, 1, 1'b0, '0},
			// clear keeps the color
			'{'{OP_CLEAR, 8'h00, 4'h0, 4'h0, 11'd0}, 1, 1'b1, '{11'd0, 8'h00, 8'h00, 8'hA5}},
			'{'{OP_READ, 8'h00, 4'h0, 4'h0, 11'd81}, 1, 1'b1,
				'{11'd0, 8'h00, BLANK_ATTR, 8'hA5}}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i])
			for (int k = 0; k < dir_tab[i].reps; k++)
				send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);

		// random part: mostly well-formed text, line feeds and readback, some noise
		while (words_sent < N_WORDS) begin
			steady = (words_sent >= 700 && words_sent < 950);
			if (!drained && words_sent >= 400) begin
				// hold off the sender until the block has nothing outstanding
				drained = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				while (expected_q.size() != 0) @(posedge clk);
			end
			kind = $urandom_range(99);
			if (kind < 30) begin
				// a line of text, usually closed by CR LF
				n = ($urandom_range(1)) ? $urandom_range(1, 20) : $urandom_range(1, 100);
				repeat (n) begin
					w = random_word();
					w.op = OP_PUT;
					do c = 8'($urandom_range(255));
					while (c == CH_BS || c == CH_TAB || c == CH_LF || c == CH_CR);
					w.ch = c;
					send_word(w, 1'b0, '0);
				end
				if ($urandom_range(3) != 0) begin
					w = random_word();
					w.op = OP_PUT;
					w.ch = CH_CR;
					send_word(w, 1'b0, '0);
				end
				if ($urandom_range(3) != 0) begin
					w = random_word();
					w.op = OP_PUT;
					w.ch = CH_LF;
					send_word(w, 1'b0, '0);
				end
			end else if (kind < 45) begin
				// burst of line feeds drives the cursor into the scroll
				repeat ($urandom_range(1, 25)) begin
					w = random_word();
					w.op = OP_PUT;
					w.ch = CH_LF;
					send_word(w, 1'b0, '0);
				end
			end else if (kind < 65) begin
				repeat ($urandom_range(1, 6)) begin
					w = random_word();
					w.op = OP_READ;
					n = $urandom_range(9);
					if (n < 6) begin
						// just behind or around the cursor, where writes landed
						at = cur_row * COLUMNS + cur_col + $urandom_range(6) - 4;
						w.idx = 11'((at < 0) ? 0 : at);
					end else if (n < 9) begin
						w.idx = 11'($urandom_range(CELLS - 1));
					end else begin
						w.idx = 11'($urandom_range(CELLS, 2047));
					end
					send_word(w, 1'b0, '0);
				end
			end else if (kind < 75) begin
				w = random_word();
				w.op = OP_COLOR;
				if ($urandom_range(2) == 0) begin
					w.fg = 4'($urandom_range(13, 15));
					w.bg = 4'h0;
				end
				send_word(w, 1'b0, '0);
			end else if (kind < 85) begin
				repeat ($urandom_range(1, 5)) begin
					w = random_word();
					w.op = OP_PUT;
					n = $urandom_range(2);
					w.ch = (n == 0) ? CH_BS : (n == 1) ? CH_TAB : CH_CR;
					send_word(w, 1'b0, '0);
				end
			end else if (kind < 98) begin
				repeat ($urandom_range(1, 4))
					send_word(random_word(), 1'b0, '0);
			end else begin
				w = random_word();
				w.op = OP_CLEAR;
				send_word(w, 1'b0, '0);
			end
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("sent %0d words, checked %0d results", words_sent, results_seen);
		$display("covered %0d scrolls, %0d row wraps, %0d clears, %0d reads past the store",
			n_scroll, n_wrap, n_clear, n_oob);
		if (fail_count == 0) begin
			$display("PASS text_console_writer");
		end else begin
			$display("%0d failures", fail_count);
			$display("FAIL text_console_writer");
		end
		$finish;
	end

endmodule
